>>> hw/rtl/ps2x_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2x_pkg
// Shared widths, register indexes, mode codes and the 2x2 block rule of the
// pixel art upscaler.
// ----------------------------------------------------------------------------
package ps2x_pkg;

   localparam int PIX_W      = 32;
   localparam int CFG_W      = 11;
   localparam int MODE_W     = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int POS_W      = 10;
   localparam int RSP_DATA_W = 152;
   localparam int RSP_PAD_W  = RSP_DATA_W - (2 * POS_W + 4 * PIX_W);

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE_MODE   = 2'd2;

   // mode codes; any other code runs the scale2x rule
   localparam logic [MODE_W-1:0] MODE_NEAREST  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SCANLINE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SCALE2X  = 2'd2;

   localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 11'd256;
   localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 11'd224;
   localparam logic [MODE_W-1:0] RST_SCALE_MODE   = MODE_SCALE2X;

   localparam logic [PIX_W-1:0] BLACK_PIXEL = 32'hff00_0000;

   typedef logic [1:0] store_idx_type;

   typedef struct packed {
      logic [PIX_W-1:0] br;
      logic [PIX_W-1:0] bl;
      logic [PIX_W-1:0] tr;
      logic [PIX_W-1:0] tl;
   } quad_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      quad_type         quad;
      logic             last;
      logic             done;
   } blk_type;

   // rotation of the three line stores
   function automatic store_idx_type sel_prev(input store_idx_type sel);
      store_idx_type res;
      res = (sel == 2'd0) ? 2'd2 : store_idx_type'(sel - 2'd1);
      return res;
   endfunction

   function automatic store_idx_type sel_next(input store_idx_type sel);
      store_idx_type res;
      res = (sel == 2'd2) ? 2'd0 : store_idx_type'(sel + 2'd1);
      return res;
   endfunction

   // zero counts as one, large values saturate
   function automatic int clamp_size(input int v, input int hi);
      int res;
      res = v;
      if (v < 1) begin
         res = 1;
      end else if (v > hi) begin
         res = hi;
      end
      return res;
   endfunction

   // E center, B up, D left, F right, H down
   function automatic quad_type scale_block(input logic [MODE_W-1:0] mode,
                                            input logic edge_col,
                                            input logic [PIX_W-1:0] e,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] d,
                                            input logic [PIX_W-1:0] f,
                                            input logic [PIX_W-1:0] h);
      quad_type q;
      q.tl = e;
      q.tr = e;
      q.bl = e;
      q.br = e;
      case (mode)
         MODE_NEAREST: begin
         end
         MODE_SCANLINE: begin
            q.bl = BLACK_PIXEL;
            q.br = BLACK_PIXEL;
         end
         default: begin
            if (!edge_col) begin
               if (d == b && b != f && d != h) q.tl = d;
               if (b == f && b != d && f != h) q.tr = f;
               if (d == h && d != b && h != f) q.bl = d;
               if (h == f && d != h && b != f) q.br = f;
            end
         end
      endcase
      return q;
   endfunction

endpackage

>>> hw/rtl/ps2x_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2x_line_ram
// One line store: one write port, one registered read port, write-first on
// a same-address collision.
// ----------------------------------------------------------------------------
module ps2x_line_ram #(
   parameter int DEPTH = ps2x_pkg::DEF_MAX_WIDTH
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [ps2x_pkg::PIX_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [ps2x_pkg::PIX_W-1:0] rd_data
);

   logic [ps2x_pkg::PIX_W-1:0] mem [DEPTH];
   logic [ps2x_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // forward the word being written so a read of it sees the new value
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_addr) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pixel_art_scale2x_upscaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_art_scale2x_upscaler_top
// Scale2x / nearest / scanline 2x upscaler for a raster stream of pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Source pixels enter on the req_ channel in raster order, one per request.
//   Each source pixel turns into one 2x2 output block on the rsp_ channel,
//   one row late: pixel (r,c) releases the block of (r-1,c). On the last
//   row the row's own blocks follow as well, one pixel late, and the last
//   pixel of the frame also releases its own block (rsp_tuser high).
//   rsp_tlast marks the last block released by a request.
//   A block passes the block stage, then the result register, to rsp.
//   Throughput: one request per cycle while rsp_tready is high; on the
//   last row a request waits until the single block stage has pushed the
//   previous request's blocks into the one-block-per-cycle result register.
//   Three line stores hold the rows; prefetch of the row above runs one
//   column ahead.
//   Writes on csr_ take effect at once; writing width or height restarts
//   the frame at row 0. Reset restores the register defaults and restarts
//   the frame; line store contents are not cleared.
//   When rsp_tready is low the result register holds and req_tready drops
//   once the block stage is full.
// ----------------------------------------------------------------------------
module pixel_art_scale2x_upscaler_top #(
   parameter int MAX_WIDTH  = ps2x_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ps2x_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] source_pixel
   input  logic [ps2x_pkg::PIX_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [9:0] source_row, [19:10] source_col, [51:20] top_left,
   // [83:52] top_right, [115:84] bottom_left, [147:116] bottom_right
   output logic [ps2x_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // [0] frame_done
   output logic                            rsp_tuser,
   input  logic                            csr_wen,
   input  logic [ps2x_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ps2x_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WSZ   = $clog2(MAX_WIDTH + 1);
   localparam int HSZ   = $clog2(MAX_HEIGHT + 1);
   localparam int DIM_W = (WSZ > HSZ) ? WSZ : HSZ;
   localparam int SZW   = ((DIM_W > ps2x_pkg::CFG_W) ? DIM_W : ps2x_pkg::CFG_W) + 1;
   localparam int PW    = ps2x_pkg::PIX_W;

   // configuration
   logic [ps2x_pkg::CFG_W-1:0]  frame_width_ff, frame_width_in;
   logic [ps2x_pkg::CFG_W-1:0]  frame_height_ff, frame_height_in;
   logic [ps2x_pkg::MODE_W-1:0] scale_mode_ff, scale_mode_in;
   logic                        restart;

   // frame position
   logic [CW-1:0]               col_cnt_ff, col_cnt_in;
   logic [RW-1:0]               row_cnt_ff, row_cnt_in;
   ps2x_pkg::store_idx_type     line_sel_ff, line_sel_in;
   logic [SZW-1:0]              w_eff, h_eff;
   logic                        last_col, last_row;
   logic                        accept;

   // block stage
   logic [2:0]                  mask_ff, mask_in, new_mask;
   logic [2:0]                  pick, remain;
   logic                        push;
   logic [RW-1:0]               s1_row_ff;
   logic [CW-1:0]               s1_col_ff;
   logic [PW-1:0]               s1_pix_ff;
   logic                        s1_use_pp_ff, s1_row0_ff, s1_last_col_ff;
   ps2x_pkg::store_idx_type     s1_ahead_sel_ff, s1_pp_sel_ff;

   // pixel windows
   logic [PW-1:0]               prv_mid_ff, prv_left_ff;
   logic [PW-1:0]               cur_left_ff, cur_left2_ff;

   // line stores
   logic [PW-1:0]               rd_data [3];
   logic [CW-1:0]               rd_addr [3];
   logic [2:0]                  wr_en;
   logic [PW-1:0]               rd_ahead, rd_pp;

   // result register
   ps2x_pkg::blk_type           blk;
   ps2x_pkg::blk_type           out_ff;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_open;

   // block operands
   logic [RW-1:0]               b_row;
   logic [CW-1:0]               b_col;
   logic [PW-1:0]               op_e, op_b, op_d, op_f, op_h;
   logic                        op_edge;
   logic [RW+ps2x_pkg::POS_W-1:0] row_wide;
   logic [CW+ps2x_pkg::POS_W-1:0] col_wide;

   assign w_eff    = SZW'(ps2x_pkg::clamp_size(int'(frame_width_ff), MAX_WIDTH));
   assign h_eff    = SZW'(ps2x_pkg::clamp_size(int'(frame_height_ff), MAX_HEIGHT));
   assign last_col = (SZW'(col_cnt_ff) + SZW'(1)) == w_eff;
   assign last_row = (SZW'(row_cnt_ff) + SZW'(1)) == h_eff;

   assign new_mask = {last_row && last_col, last_row && (col_cnt_ff != '0),
                      row_cnt_ff != '0};

   assign out_open   = !out_valid_ff || rsp_tready;
   assign pick       = mask_ff & ~(mask_ff - 3'd1);
   assign remain     = mask_ff & ~pick;
   assign push       = (mask_ff != 3'd0) && out_open;
   assign req_tready = (mask_ff == 3'd0) || (push && remain == 3'd0);
   assign accept     = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // configuration writes and frame position
   // ---------------------------------------------------------------------
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      scale_mode_in   = scale_mode_ff;
      restart         = 1'b0;
      if (csr_wen) begin
         unique case (csr_addr)
            ps2x_pkg::CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wdata;
               restart        = 1'b1;
            end
            ps2x_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata;
               restart         = 1'b1;
            end
            ps2x_pkg::CSR_SCALE_MODE: begin
               scale_mode_in = csr_wdata[ps2x_pkg::MODE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      col_cnt_in  = col_cnt_ff;
      row_cnt_in  = row_cnt_ff;
      line_sel_in = line_sel_ff;
      if (restart) begin
         col_cnt_in  = '0;
         row_cnt_in  = '0;
         line_sel_in = 2'd0;
      end else if (accept) begin
         if (!last_col) begin
            col_cnt_in = col_cnt_ff + CW'(1);
         end else begin
            col_cnt_in = '0;
            if (!last_row) begin
               row_cnt_in  = row_cnt_ff + RW'(1);
               line_sel_in = ps2x_pkg::sel_next(line_sel_ff);
            end else begin
               row_cnt_in  = '0;
               line_sel_in = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= ps2x_pkg::RST_FRAME_WIDTH;
         frame_height_ff <= ps2x_pkg::RST_FRAME_HEIGHT;
         scale_mode_ff   <= ps2x_pkg::RST_SCALE_MODE;
         col_cnt_ff      <= '0;
         row_cnt_ff      <= '0;
         line_sel_ff     <= 2'd0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         scale_mode_ff   <= scale_mode_in;
         col_cnt_ff      <= col_cnt_in;
         row_cnt_ff      <= row_cnt_in;
         line_sel_ff     <= line_sel_in;
      end
   end

   // ---------------------------------------------------------------------
   // line stores: write the current row, prefetch the row above one column
   // ahead and the row two above at this column; at the end of a row,
   // prefetch column 0 of the row just finished for the next row
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < 3; k++) begin : g_store
      always_comb begin
         wr_en[k] = accept && (line_sel_ff == 2'(k));
         if (line_sel_ff == 2'(k)) begin
            rd_addr[k] = '0;
         end else if (ps2x_pkg::sel_prev(line_sel_ff) == 2'(k)) begin
            rd_addr[k] = col_cnt_ff + CW'(1);
         end else begin
            rd_addr[k] = col_cnt_ff;
         end
      end

      ps2x_line_ram #(
         .DEPTH(MAX_WIDTH)
      ) u_line_ram (
         .clock  (clock),
         .wr_en  (wr_en[k]),
         .wr_addr(col_cnt_ff),
         .wr_data(req_tdata),
         .rd_en  (accept),
         .rd_addr(rd_addr[k]),
         .rd_data(rd_data[k])
      );
   end

   always_comb begin
      case (s1_ahead_sel_ff)
         2'd0:    rd_ahead = rd_data[0];
         2'd1:    rd_ahead = rd_data[1];
         default: rd_ahead = rd_data[2];
      endcase
      case (s1_pp_sel_ff)
         2'd0:    rd_pp = rd_data[0];
         2'd1:    rd_pp = rd_data[1];
         default: rd_pp = rd_data[2];
      endcase
   end

   // ---------------------------------------------------------------------
   // block stage
   // ---------------------------------------------------------------------
   always_comb begin
      mask_in = mask_ff;
      if (accept) begin
         mask_in = new_mask;
      end else if (push) begin
         mask_in = remain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 3'd0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff       <= row_cnt_ff;
         s1_col_ff       <= col_cnt_ff;
         s1_pix_ff       <= req_tdata;
         s1_use_pp_ff    <= row_cnt_ff > RW'(1);
         s1_row0_ff      <= row_cnt_ff == '0;
         s1_last_col_ff  <= last_col;
         s1_ahead_sel_ff <= last_col ? line_sel_ff : ps2x_pkg::sel_prev(line_sel_ff);
         s1_pp_sel_ff    <= ps2x_pkg::sel_next(line_sel_ff);
         // advance the windows by one column
         prv_mid_ff      <= rd_ahead;
         prv_left_ff     <= prv_mid_ff;
         cur_left_ff     <= s1_pix_ff;
         cur_left2_ff    <= cur_left_ff;
      end
   end

   always_comb begin
      if (pick[0]) begin
         // block of the row above
         b_row   = s1_row_ff - RW'(1);
         b_col   = s1_col_ff;
         op_e    = prv_mid_ff;
         op_b    = s1_use_pp_ff ? rd_pp : prv_mid_ff;
         op_d    = prv_left_ff;
         op_f    = rd_ahead;
         op_h    = s1_pix_ff;
         op_edge = (s1_col_ff == '0) || s1_last_col_ff;
      end else if (pick[1]) begin
         // last row, block one column back
         b_row   = s1_row_ff;
         b_col   = s1_col_ff - CW'(1);
         op_e    = cur_left_ff;
         op_b    = s1_row0_ff ? cur_left_ff : prv_left_ff;
         op_d    = cur_left2_ff;
         op_f    = s1_pix_ff;
         op_h    = cur_left_ff;
         op_edge = s1_col_ff == CW'(1);
      end else begin
         // last row, last column
         b_row   = s1_row_ff;
         b_col   = s1_col_ff;
         op_e    = s1_pix_ff;
         op_b    = s1_pix_ff;
         op_d    = s1_pix_ff;
         op_f    = s1_pix_ff;
         op_h    = s1_pix_ff;
         op_edge = 1'b1;
      end
   end

   assign row_wide = {{ps2x_pkg::POS_W{1'b0}}, b_row};
   assign col_wide = {{ps2x_pkg::POS_W{1'b0}}, b_col};

   always_comb begin
      blk.row  = row_wide[ps2x_pkg::POS_W-1:0];
      blk.col  = col_wide[ps2x_pkg::POS_W-1:0];
      blk.quad = ps2x_pkg::scale_block(scale_mode_ff, op_edge, op_e, op_b, op_d,
                                       op_f, op_h);
      blk.last = remain == 3'd0;
      blk.done = pick[2];
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   always_comb begin
      out_valid_in = out_valid_ff;
      if (push) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_ff <= blk;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{ps2x_pkg::RSP_PAD_W{1'b0}}, out_ff.quad.br, out_ff.quad.bl,
                        out_ff.quad.tr, out_ff.quad.tl, out_ff.col, out_ff.row};
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = out_ff.done;

`ifndef SYNTHESIS
   a_single_block_accept: assert property (@(posedge clock) disable iff (reset)
      ($countones(mask_ff) > 1) |-> !req_tready)
      else $error("request taken while block stage still owes several blocks");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("frame end block not marked last of its request");

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      SZW'(col_cnt_ff) < w_eff)
      else $error("column counter outside frame width");

   a_own_block_done: assert property (@(posedge clock) disable iff (reset)
      (push && pick[2]) |=> (rsp_tvalid && rsp_tuser))
      else $error("final block of frame lost its frame end flag");
`endif

endmodule
